[hdl/mtt_pkg.sv]
`default_nettype none

package mtt_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_TEXT  = 3'd2,
        KIND_OK    = 3'd3,
        KIND_ERR   = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        M_START       = 4'd0,
        M_TEXT_FIRST  = 4'd1,
        M_TEXT        = 4'd2,
        M_AFTER_LT    = 4'd3,
        M_OPEN        = 4'd4,
        M_SKIP_EMPTY  = 4'd5,
        M_SKIP_HELD   = 4'd6,
        M_CLOSE_FIRST = 4'd7,
        M_CLOSE       = 4'd8
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] char_value;
        logic       has_char;
        logic       last_of_token;
    } out_item_t;

    // results of one step, handed from the scanner to the queue
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_res_t;

    function automatic out_item_t make_item(kind_t kind, logic [7:0] ch, logic has,
                                            logic last);
        out_item_t item;
        item.token_kind    = kind;
        item.char_value    = has ? ch : 8'h00;
        item.has_char      = has;
        item.last_of_token = last;
        return item;
    endfunction

endpackage

`default_nettype wire

[hdl/markup_tag_tokenizer_unit.sv]
`default_nettype none

// Streaming tag tokenizer: one byte (or an end-of-input mark) per item in, a stream of
// token characters out, each tagged with its kind (open tag, close tag, text, end ok,
// end error) and a last flag; empty tokens come out as one item without a character.
// An item is taken every clock while the four-entry output queue has room for two
// results; a byte gives at most one result, an end mark up to two (pending tag, then
// end ok). Results are registered in the output queue and leave it in order, one per clock
// while res_stall is low, so a sink that never stalls sees no backpressure on byte traffic.
module markup_tag_tokenizer_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire mtt_pkg::in_item_t  src_item,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output mtt_pkg::out_item_t      res_item
);
    import mtt_pkg::*;

    logic      fire;
    logic      q_full;
    step_res_t step_res;
    step_res_t push;

    assign src_stall = q_full;
    assign fire      = src_valid && !q_full;

    always_comb
    begin
        push = step_res;
        if (!fire)
            push.count = 2'd0;
    end

    mtt_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (src_item),
        .res   (step_res)
    );

    mtt_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (res_valid && !res_stall),
        .full  (q_full),
        .valid (res_valid),
        .head  (res_item)
    );

endmodule

`default_nettype wire

[hdl/mtt_scan.sv]
`default_nettype none

module mtt_scan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire mtt_pkg::in_item_t item,
    output mtt_pkg::step_res_t     res
);
    import mtt_pkg::*;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [7:0] b;
    logic       is_end;

    assign b      = item.byte_value;
    assign is_end = item.end_of_input;

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        if (is_end)
        begin
            mode_next = M_START;
            held_next = 8'h00;
        end
        else
        begin
            case (mode_reg)
                M_TEXT_FIRST:
                begin
                    if (b == CH_LT)
                        mode_next = M_AFTER_LT;
                    else
                    begin
                        held_next = b;
                        mode_next = M_TEXT;
                    end
                end
                M_TEXT:
                begin
                    if (b == CH_LT)
                        mode_next = M_AFTER_LT;
                    else
                        held_next = b;
                end
                M_AFTER_LT:
                begin
                    if (b == CH_SLASH)
                        mode_next = M_CLOSE_FIRST;
                    else if (b == CH_GT)
                        mode_next = M_TEXT_FIRST;
                    else if (b == CH_SPACE)
                        mode_next = M_SKIP_EMPTY;
                    else
                    begin
                        held_next = b;
                        mode_next = M_OPEN;
                    end
                end
                M_OPEN:
                begin
                    if (b == CH_GT)
                        mode_next = M_TEXT_FIRST;
                    else if (b == CH_SPACE)
                        mode_next = M_SKIP_HELD;
                    else
                        held_next = b;
                end
                M_SKIP_EMPTY, M_SKIP_HELD:
                begin
                    if (b == CH_GT)
                        mode_next = M_TEXT_FIRST;
                end
                M_CLOSE_FIRST:
                begin
                    if (b == CH_GT)
                        mode_next = M_TEXT_FIRST;
                    else
                    begin
                        held_next = b;
                        mode_next = M_CLOSE;
                    end
                end
                M_CLOSE:
                begin
                    if (b == CH_GT)
                        mode_next = M_TEXT_FIRST;
                    else
                        held_next = b;
                end
                default:
                begin
                    mode_next = (b == CH_LT) ? M_AFTER_LT : M_TEXT_FIRST;
                end
            endcase
        end
    end

    // results
    always_comb
    begin
        res = '0;
        if (is_end)
        begin
            res.count  = 2'd2;
            res.second = make_item(KIND_OK, 8'h00, 1'b0, 1'b1);
            case (mode_reg)
                M_TEXT, M_OPEN, M_CLOSE:
                begin
                    res.count = 2'd1;
                    res.first = make_item(KIND_ERR, 8'h00, 1'b0, 1'b1);
                end
                M_AFTER_LT, M_SKIP_EMPTY:
                    res.first = make_item(KIND_OPEN, 8'h00, 1'b0, 1'b1);
                M_SKIP_HELD:
                    res.first = make_item(KIND_OPEN, held_reg, 1'b1, 1'b1);
                M_CLOSE_FIRST:
                    res.first = make_item(KIND_CLOSE, 8'h00, 1'b0, 1'b1);
                default:
                begin
                    res.count = 2'd1;
                    res.first = make_item(KIND_OK, 8'h00, 1'b0, 1'b1);
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                M_TEXT_FIRST:
                begin
                    if (b == CH_LT)
                    begin
                        res.count = 2'd1;
                        res.first = make_item(KIND_TEXT, 8'h00, 1'b0, 1'b1);
                    end
                end
                M_TEXT:
                begin
                    res.count = 2'd1;
                    res.first = make_item(KIND_TEXT, held_reg, 1'b1, b == CH_LT);
                end
                M_AFTER_LT:
                begin
                    if (b == CH_GT)
                    begin
                        res.count = 2'd1;
                        res.first = make_item(KIND_OPEN, 8'h00, 1'b0, 1'b1);
                    end
                end
                M_OPEN:
                begin
                    if (b != CH_SPACE)
                    begin
                        res.count = 2'd1;
                        res.first = make_item(KIND_OPEN, held_reg, 1'b1, b == CH_GT);
                    end
                end
                M_SKIP_EMPTY:
                begin
                    if (b == CH_GT)
                    begin
                        res.count = 2'd1;
                        res.first = make_item(KIND_OPEN, 8'h00, 1'b0, 1'b1);
                    end
                end
                M_SKIP_HELD:
                begin
                    if (b == CH_GT)
                    begin
                        res.count = 2'd1;
                        res.first = make_item(KIND_OPEN, held_reg, 1'b1, 1'b1);
                    end
                end
                M_CLOSE_FIRST:
                begin
                    if (b == CH_GT)
                    begin
                        res.count = 2'd1;
                        res.first = make_item(KIND_CLOSE, 8'h00, 1'b0, 1'b1);
                    end
                end
                M_CLOSE:
                begin
                    res.count = 2'd1;
                    res.first = make_item(KIND_CLOSE, held_reg, 1'b1, b == CH_GT);
                end
                default:
                begin
                    res.count = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_START;
            held_reg <= 8'h00;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_end |-> res.count != 2'd0 && res.count != 2'd3)
        else $error("end item produced no result");

    a_byte_single: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !is_end |-> res.count == 2'd0 || res.count == 2'd1)
        else $error("byte item produced more than one result");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_end |=> mode_reg == M_START && held_reg == 8'h00)
        else $error("scanner did not restart after end");
`endif

endmodule

`default_nettype wire

[hdl/mtt_outq.sv]
`default_nettype none

module mtt_outq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mtt_pkg::step_res_t push,
    input  wire logic               pop,
    output logic                    full,
    output logic                    valid,
    output mtt_pkg::out_item_t      head
);
    import mtt_pkg::*;

    out_item_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   head_next;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QPTR_W-1:0]   tail_next;
    logic [QPTR_W-1:0]   tail_plus1;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // room for the worst case of one step is required before taking an item
    assign full       = count_reg > QCNT_W'(QDEPTH - 2);
    assign valid      = count_reg != '0;
    assign head       = entry_reg[head_reg];
    assign tail_plus1 = tail_reg + 1'b1;

    assign head_next  = pop ? head_reg + 1'b1 : head_reg;
    assign tail_next  = tail_reg + QPTR_W'(push.count);
    assign count_next = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (push.count != 2'd0 && tail_reg == QPTR_W'(i))
                entry_reg[i] <= push.first;
            else if (push.count == 2'd2 && tail_plus1 == QPTR_W'(i))
                entry_reg[i] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> count_reg <= QCNT_W'(QDEPTH - 2))
        else $error("double push without room");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
